[rtl/rgbhist_pkg.sv]
// Shared types and request codes for the RGB histogram block.
// Used by rgbhist_chan and rgb16_histogram_256_bins; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rgbhist_pkg;

	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 8;
	localparam int REQ_W    = 2;
	localparam int OUT_W    = 32;

	localparam logic [REQ_W-1:0] REQ_COUNT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// Per-channel controls from the top level sequencer.
	typedef struct packed {
		logic rd_en;    // item accepted, launch bin read
		logic upd_en;   // count item in s1, write back incremented bin
		logic hold;     // s1 item stalled, keep forwarding state
		logic clr;      // clear item in s1, zero the peak
		logic sweep_we; // clearing sweep writes zero
	} chan_ctl_t;

endpackage

`default_nettype wire

[rtl/rgbhist_ram.sv]
// Generic single-clock RAM: one write port, one registered read port.
// Read during a write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rgbhist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

[rtl/rgbhist_chan.sv]
// One color channel: bin RAM, read-modify-write with one-deep forwarding,
// saturating increment and running peak. Depends on rgbhist_pkg and rgbhist_ram.
`timescale 1ns / 1ps
`default_nettype none

module rgbhist_chan #(
	parameter int NUM_BINS    = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rgbhist_pkg::chan_ctl_t      ctl,
	input  wire logic [$clog2(NUM_BINS)-1:0] rd_addr,
	input  wire logic [$clog2(NUM_BINS)-1:0] sweep_addr,
	output      logic [COUNT_WIDTH-1:0]      count,
	output      logic [COUNT_WIDTH-1:0]      peak
);

	import rgbhist_pkg::*;

	localparam int AW = $clog2(NUM_BINS);

	logic [AW-1:0]          addr_s1;
	logic [COUNT_WIDTH-1:0] rdata;
	logic                   fwd_valid_q;
	logic [AW-1:0]          fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH:0]   inc;
	logic [COUNT_WIDTH-1:0] next_cnt;
	logic [COUNT_WIDTH-1:0] peak_q;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	// The RAM read was launched in the same edge as the previous write,
	// so take that write's value when the bins match.
	assign cur      = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata;
	assign inc      = {1'b0, cur} + {{COUNT_WIDTH{1'b0}}, 1'b1};
	assign next_cnt = inc[COUNT_WIDTH] ? cur : inc[COUNT_WIDTH-1:0];

	assign ram_we    = ctl.sweep_we || ctl.upd_en;
	assign ram_waddr = ctl.sweep_we ? sweep_addr : addr_s1;
	assign ram_wdata = ctl.sweep_we ? '0 : next_cnt;

	rgbhist_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			addr_s1 <= rd_addr;
		end
		if (ctl.upd_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= next_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			peak_q      <= '0;
		end else begin
			if (ctl.clr) begin
				fwd_valid_q <= 1'b0;
			end else if (!ctl.hold) begin
				fwd_valid_q <= ctl.upd_en;
			end
			if (ctl.clr) begin
				peak_q <= '0;
			end else if (ctl.upd_en && next_cnt > peak_q) begin
				peak_q <= next_cnt;
			end
		end
	end

	assign count = cur;
	assign peak  = peak_q;

	// Counts only grow, so the peak may only drop on a clear.
	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.clr |=> peak_q >= $past(peak_q))
		else $error("peak decreased without a clear");

endmodule

`default_nettype wire

[rtl/rgb16_histogram_256_bins.sv]
// Top level of the three-channel RGB histogram.
// Depends on rgbhist_pkg and rgbhist_chan (which holds rgbhist_ram).
//
// Each channel's counts live in a NUM_BINS-deep RAM with a registered read.
// Count and read items are taken one per cycle while in_stall is low: an item
// reads its bins in the cycle it is accepted and a count item writes the
// incremented bin back in the next cycle, with the previous write forwarded
// when two neighbors hit the same bin. A read item's result passes through s1
// into the output register; while that register is full and stalled, a read
// item waits in s1 and no new item is taken. A clear item holds the input
// while it sits in s1 and until its sweep ends: it zeroes the peaks, then
// sweeps the three RAMs one bin per cycle. The same sweep runs after reset
// before the first item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module rgb16_histogram_256_bins #(
	parameter int NUM_BINS    = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [rgbhist_pkg::REQ_W-1:0] req_type,
	input  wire logic [rgbhist_pkg::SAMPLE_W-1:0] red,
	input  wire logic [rgbhist_pkg::SAMPLE_W-1:0] green,
	input  wire logic [rgbhist_pkg::SAMPLE_W-1:0] blue,
	input  wire logic [rgbhist_pkg::INDEX_W-1:0]  bin_index,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [rgbhist_pkg::OUT_W-1:0] count_red,
	output      logic [rgbhist_pkg::OUT_W-1:0] count_green,
	output      logic [rgbhist_pkg::OUT_W-1:0] count_blue,
	output      logic [rgbhist_pkg::OUT_W-1:0] peak_red,
	output      logic [rgbhist_pkg::OUT_W-1:0] peak_green,
	output      logic [rgbhist_pkg::OUT_W-1:0] peak_blue
);

	import rgbhist_pkg::*;

	localparam int AW = $clog2(NUM_BINS);
	localparam int PW = SAMPLE_W + AW + 1;
	localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

	// Bin of a sample: (sample * NUM_BINS) >> 16, always below NUM_BINS.
	function automatic logic [AW-1:0] bin_of(input logic [SAMPLE_W-1:0] s);
		logic [PW-1:0] p;
		p = PW'(s) * PW'(NUM_BINS);
		return AW'(p >> SAMPLE_W);
	endfunction

	logic             accept;
	logic             is_read;
	logic [AW-1:0]    idx_addr;
	logic             idx_in_range;
	logic             s1_valid_q;
	logic [REQ_W-1:0] s1_type_q;
	logic             s1_in_range_q;
	logic             s1_read;
	logic             s1_clear;
	logic             s1_count;
	logic             s1_hold;
	logic             clr_busy_q;
	logic [AW-1:0]    clr_addr_q;
	chan_ctl_t        ctl;

	logic [AW-1:0]          addr_r, addr_g, addr_b;
	logic [COUNT_WIDTH-1:0] cnt_r, cnt_g, cnt_b;
	logic [COUNT_WIDTH-1:0] pk_r, pk_g, pk_b;

	logic             out_valid_q;
	logic [OUT_W-1:0] count_red_q, count_green_q, count_blue_q;
	logic [OUT_W-1:0] peak_red_q, peak_green_q, peak_blue_q;

	assign s1_read  = s1_valid_q && s1_type_q == REQ_READ;
	assign s1_clear = s1_valid_q && s1_type_q == REQ_CLEAR;
	assign s1_count = s1_valid_q && s1_type_q == REQ_COUNT;
	assign s1_hold  = s1_read && out_valid_q && out_stall;

	assign in_stall = clr_busy_q || s1_clear || s1_hold;
	assign accept   = in_valid && !in_stall;

	assign is_read      = req_type == REQ_READ;
	assign idx_addr     = AW'(bin_index);
	assign idx_in_range = 32'(bin_index) < 32'(NUM_BINS);

	assign addr_r = is_read ? idx_addr : bin_of(red);
	assign addr_g = is_read ? idx_addr : bin_of(green);
	assign addr_b = is_read ? idx_addr : bin_of(blue);

	assign ctl.rd_en    = accept;
	assign ctl.upd_en   = s1_count;
	assign ctl.hold     = s1_hold;
	assign ctl.clr      = s1_clear;
	assign ctl.sweep_we = clr_busy_q;

	rgbhist_chan #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_chan_red (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .rd_addr(addr_r),
		.sweep_addr(clr_addr_q), .count(cnt_r), .peak(pk_r)
	);

	rgbhist_chan #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_chan_green (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .rd_addr(addr_g),
		.sweep_addr(clr_addr_q), .count(cnt_g), .peak(pk_g)
	);

	rgbhist_chan #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_chan_blue (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .rd_addr(addr_b),
		.sweep_addr(clr_addr_q), .count(cnt_b), .peak(pk_b)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_type_q     <= req_type;
			s1_in_range_q <= idx_in_range;
		end
		if (s1_read && !s1_hold) begin
			count_red_q   <= s1_in_range_q ? OUT_W'(cnt_r) : '0;
			count_green_q <= s1_in_range_q ? OUT_W'(cnt_g) : '0;
			count_blue_q  <= s1_in_range_q ? OUT_W'(cnt_b) : '0;
			peak_red_q    <= OUT_W'(pk_r);
			peak_green_q  <= OUT_W'(pk_g);
			peak_blue_q   <= OUT_W'(pk_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			if (!s1_hold) begin
				s1_valid_q <= accept;
			end

			if (s1_read && !s1_hold) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Sweep one bin per cycle, starting when a clear item sits in s1.
			priority if (s1_clear) begin
				clr_busy_q <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_busy_q) begin
				if (clr_addr_q == LAST_BIN) begin
					clr_busy_q <= 1'b0;
					clr_addr_q <= '0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end else begin
				// idle: hold the sweep pointer at the first bin
				clr_addr_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign count_red   = count_red_q;
	assign count_green = count_green_q;
	assign count_blue  = count_blue_q;
	assign peak_red    = peak_red_q;
	assign peak_green  = peak_green_q;
	assign peak_blue   = peak_blue_q;

	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		s1_clear |=> clr_busy_q && clr_addr_q == '0)
		else $error("clear item did not start the sweep");

	a_no_count_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s1_count)
		else $error("count write overlaps the clearing sweep");

	a_read_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_read && !s1_hold) |=> out_valid_q)
		else $error("read item lost on its way to the output register");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_busy_q && !s1_clear && clr_addr_q == LAST_BIN) |=> !clr_busy_q)
		else $error("clearing sweep ran past the last bin");

endmodule

`default_nettype wire

[sim/rgb16_histogram_256_bins_test.sv]
// Self-checking bench for rgb16_histogram_256_bins: random and directed requests
// are scored against a local model of the three RGB histograms and their peaks.
// Depends on rgbhist_pkg and the RTL of the histogram block.
`timescale 1ns / 1ps

module rgb16_histogram_256_bins_test;

	import rgbhist_pkg::*;

	localparam int NUM_BINS     = 256;
	localparam int RANDOM_ITEMS = 850;
	localparam int STALL_PCT    = 23;
	localparam int HANG_LIMIT   = 4000;
	localparam int CALM_FIRST   = 350;
	localparam int CALM_LAST    = 500;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]    kind;
		logic [SAMPLE_W-1:0] r;
		logic [SAMPLE_W-1:0] g;
		logic [SAMPLE_W-1:0] b;
		logic [INDEX_W-1:0]  idx;
	} hist_req_t;

	typedef struct packed {
		logic [OUT_W-1:0] cnt_r;
		logic [OUT_W-1:0] cnt_g;
		logic [OUT_W-1:0] cnt_b;
		logic [OUT_W-1:0] pk_r;
		logic [OUT_W-1:0] pk_g;
		logic [OUT_W-1:0] pk_b;
	} bin_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = REQ_COUNT;
	logic [SAMPLE_W-1:0] red = '0;
	logic [SAMPLE_W-1:0] green = '0;
	logic [SAMPLE_W-1:0] blue = '0;
	logic [INDEX_W-1:0] bin_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] count_red, count_green, count_blue;
	logic [OUT_W-1:0] peak_red, peak_green, peak_blue;

	hist_req_t   pending_reqs[$];
	bin_report_t reads_due[$];

	// local copy of the histograms: [channel][bin], channel 0 red, 1 green, 2 blue
	logic [OUT_W-1:0] model_bins [3][NUM_BINS];
	logic [OUT_W-1:0] model_peak [3];

	logic in_taken = 1'b0;
	int   reqs_taken = 0;
	int   errors = 0;
	int   quiet_cycles = 0;
	int   pixels_counted = 0;
	int   reads_checked = 0;
	int   clears_done = 0;
	int   unused_seen = 0;

	logic [INDEX_W-1:0] hot_bins [4] = '{8'h00, 8'h7f, 8'h80, 8'hff};

	rgb16_histogram_256_bins uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.red(red),
		.green(green),
		.blue(blue),
		.bin_index(bin_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.count_red(count_red),
		.count_green(count_green),
		.count_blue(count_blue),
		.peak_red(peak_red),
		.peak_green(peak_green),
		.peak_blue(peak_blue)
	);

	always #2 clk = ~clk;

	task automatic wipe_model();
		int ch;
		int i;
		for (ch = 0; ch < 3; ch++) begin
			for (i = 0; i < NUM_BINS; i++)
				model_bins[ch][i] = '0;
			model_peak[ch] = '0;
		end
	endtask

	task automatic add_req(input logic [REQ_W-1:0] kind, input logic [SAMPLE_W-1:0] r,
			input logic [SAMPLE_W-1:0] g, input logic [SAMPLE_W-1:0] b,
			input logic [INDEX_W-1:0] idx);
		hist_req_t it;
		it.kind = kind;
		it.r = r;
		it.g = g;
		it.b = b;
		it.idx = idx;
		pending_reqs.push_back(it);
	endtask

	// bias toward a few bins so counts climb and neighbors collide
	function automatic logic [SAMPLE_W-1:0] pick_sample(input bit hot);
		if (hot)
			return {hot_bins[$urandom_range(3)], 8'($urandom)};
		return SAMPLE_W'($urandom);
	endfunction

	task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
			errors++;
		end
	endtask

	function automatic bit calm_window();
		return reqs_taken >= CALM_FIRST && reqs_taken < CALM_LAST;
	endfunction

	// Driver: advance to the next item once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_reqs.size() != 0 &&
					(calm_window() || $urandom_range(99) >= STALL_PCT)) begin
				req_type  <= pending_reqs[0].kind;
				red       <= pending_reqs[0].r;
				green     <= pending_reqs[0].g;
				blue      <= pending_reqs[0].b;
				bin_index <= pending_reqs[0].idx;
				in_valid  <= 1'b1;
				void'(pending_reqs.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && !calm_window() && ($urandom_range(99) < STALL_PCT);
	end

	// Monitor: score results, then update the model with the item taken at this edge.
	always @(posedge clk) begin
		bin_report_t want;
		logic [SAMPLE_W-1:0] smp [3];
		logic [INDEX_W-1:0] b;
		int ch;
		bit took_in;
		bit took_out;
		took_in = arst_n && in_valid && !in_stall;
		took_out = arst_n && out_valid && !out_stall;
		in_taken <= took_in;

		if (took_out) begin
			if (reads_due.size() == 0) begin
				$display("%0t ns: result with no read pending, expected none, actual %0d/%0d/%0d",
					$time, count_red, count_green, count_blue);
				errors++;
			end else begin
				want = reads_due.pop_front();
				compare_field("count_red", want.cnt_r, count_red);
				compare_field("count_green", want.cnt_g, count_green);
				compare_field("count_blue", want.cnt_b, count_blue);
				compare_field("peak_red", want.pk_r, peak_red);
				compare_field("peak_green", want.pk_g, peak_green);
				compare_field("peak_blue", want.pk_b, peak_blue);
				reads_checked++;
			end
		end

		if (took_in) begin
			reqs_taken++;
			case (req_type)
				REQ_COUNT: begin
					smp[0] = red;
					smp[1] = green;
					smp[2] = blue;
					for (ch = 0; ch < 3; ch++) begin
						b = smp[ch][SAMPLE_W-1 -: INDEX_W];
						if (model_bins[ch][b] != '1)
							model_bins[ch][b] = model_bins[ch][b] + 1'b1;
						if (model_bins[ch][b] > model_peak[ch])
							model_peak[ch] = model_bins[ch][b];
					end
					pixels_counted++;
				end
				REQ_READ: begin
					want.cnt_r = model_bins[0][bin_index];
					want.cnt_g = model_bins[1][bin_index];
					want.cnt_b = model_bins[2][bin_index];
					want.pk_r = model_peak[0];
					want.pk_g = model_peak[1];
					want.pk_b = model_peak[2];
					reads_due.push_back(want);
				end
				REQ_CLEAR: begin
					wipe_model();
					clears_done++;
				end
				default: unused_seen++;
			endcase
		end

		if (took_in || took_out)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("%0t ns: no item moved for %0d cycles", $time, HANG_LIMIT);
			$display("rgb16_histogram_256_bins test failed");
			$finish;
		end
	end

	initial begin
		int n;
		int roll;
		bit hot;
		wipe_model();

		// directed: empty read, sample extremes, bin edges, repeats, unused code, clear
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		add_req(REQ_COUNT, 16'h0000, 16'hffff, 16'h8000, 8'h00);
		add_req(REQ_COUNT, 16'hffff, 16'h0000, 16'h7fff, 8'hff);
		add_req(REQ_COUNT, 16'h00ff, 16'h0100, 16'hff00, 8'h55);
		add_req(REQ_COUNT, 16'h00ff, 16'h0100, 16'hff00, 8'haa);
		add_req(REQ_COUNT, 16'h00ff, 16'h0100, 16'hff00, 8'h00);
		add_req(REQ_READ, 16'hffff, 16'hffff, 16'hffff, 8'h00);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'hff);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'h01);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'h80);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'h7f);
		add_req(REQ_UNUSED, 16'haaaa, 16'h5555, 16'hffff, 8'h00);
		add_req(REQ_UNUSED, 16'h5555, 16'haaaa, 16'h0000, 8'hff);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'hff);
		add_req(REQ_CLEAR, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'hff);
		add_req(REQ_COUNT, 16'h1234, 16'h1234, 16'h1234, 8'h00);
		add_req(REQ_COUNT, 16'h12ff, 16'h1200, 16'h1280, 8'h00);
		add_req(REQ_COUNT, 16'h1201, 16'h12fe, 16'h127f, 8'h00);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'h12);
		add_req(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 8'h13);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			hot = $urandom_range(1);
			if (roll < 66) begin
				add_req(REQ_COUNT, pick_sample(hot), pick_sample(hot), pick_sample(hot),
					INDEX_W'($urandom));
				n++;
			end else if (roll < 92) begin
				add_req(REQ_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
					SAMPLE_W'($urandom),
					hot ? hot_bins[$urandom_range(3)] : INDEX_W'($urandom));
				n++;
			end else if (roll < 94) begin
				add_req(REQ_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
					SAMPLE_W'($urandom), INDEX_W'($urandom));
				n++;
			end else begin
				add_req(REQ_UNUSED, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
					SAMPLE_W'($urandom), INDEX_W'($urandom));
				n++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (reads_due.size() != 0)
			@(posedge clk);
		// a trailing clear or count may still be busy; watch for stray results
		repeat (NUM_BINS + 40) @(posedge clk);

		$display("Counted %0d pixels, checked %0d reads, ran %0d clears,",
			pixels_counted, reads_checked, clears_done);
		$display("and skipped %0d unused requests.", unused_seen);
		if (errors == 0)
			$display("rgb16_histogram_256_bins test passed");
		else
			$display("rgb16_histogram_256_bins test failed");
		$finish;
	end

endmodule

[rgb16_histogram_256_bins.f]
rtl/rgbhist_pkg.sv
rtl/rgbhist_ram.sv
rtl/rgbhist_chan.sv
rtl/rgb16_histogram_256_bins.sv
sim/rgb16_histogram_256_bins_test.sv
